FILE: sv/fha_pkg.sv
// ----------------------------------------------------------------------------
// fha_pkg: shared types and constants
// Status codes, fit strategy codes and sequencer states for the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fha_pkg;

    localparam int FREE_ENTRIES_DEF = 16;
    localparam int HEAP_UNITS_DEF   = 65536;

    localparam int ADDR_W   = 16;
    localparam int REQ_W    = 8;
    localparam int STATUS_W = 3;
    localparam int TOPOUT_W = 17;
    localparam int STRAT_W  = 2;

    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED     = 3'd0,
        ST_GREW       = 3'd1,
        ST_HEAP_FULL  = 3'd2,
        ST_FREED      = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: sv/fha_cell.sv
// ----------------------------------------------------------------------------
// fha_cell: one free table entry
// Holds valid, start and length; takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module fha_cell #(
    parameter int TOP_W = 17
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              shift_en,
    input  wire              in_valid,
    input  wire [TOP_W-1:0]  in_start,
    input  wire [TOP_W-1:0]  in_len,
    output logic             out_valid,
    output logic [TOP_W-1:0] out_start,
    output logic [TOP_W-1:0] out_len
);

    logic             valid_reg;
    logic [TOP_W-1:0] start_reg;
    logic [TOP_W-1:0] len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            start_reg <= in_start;
            len_reg   <= in_len;
        end
    end

    assign out_valid = valid_reg;
    assign out_start = start_reg;
    assign out_len   = len_reg;

endmodule

`default_nettype wire

FILE: sv/fit_strategy_heap_allocator.sv
// From input transfer to result valid the sequencer passes the scan, apply and done states.
// A new item is taken only in idle, once the last one is done; the free table is a ring of
// cells rotated once to scan and once more to apply the update.
// A new item is taken while the previous result still waits on m_ready.
// Reset: synchronous, active low; empties the table, clears heap top and strategy.
// ----------------------------------------------------------------------------
// fit_strategy_heap_allocator: first/best/worst fit heap allocator
// Ring of entry cells scanned at the tail cell; split, merge and insert applied
// on the second rotation as each entry passes back into the head cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_strategy_heap_allocator #(
    parameter int FREE_ENTRIES = fha_pkg::FREE_ENTRIES_DEF,
    parameter int HEAP_UNITS   = fha_pkg::HEAP_UNITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire [fha_pkg::STRAT_W-1:0]   cfg_wr_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_action,
    input  wire [fha_pkg::REQ_W-1:0]     s_request_length,
    input  wire [fha_pkg::ADDR_W-1:0]    s_free_address,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [fha_pkg::ADDR_W-1:0]   m_granted_address,
    output logic [fha_pkg::STATUS_W-1:0] m_status,
    output logic [fha_pkg::TOPOUT_W-1:0] m_heap_top_now
);
    import fha_pkg::*;

    localparam int TOP_W = $clog2(HEAP_UNITS + 1);
    localparam int IW    = $clog2(FREE_ENTRIES);
    localparam logic [IW-1:0]    LAST_IDX = IW'(FREE_ENTRIES - 1);
    localparam logic [TOP_W+1:0] CAP      = (TOP_W+2)'(HEAP_UNITS);

    // ring taps
    logic             cv [FREE_ENTRIES];
    logic [TOP_W-1:0] cs [FREE_ENTRIES];
    logic [TOP_W-1:0] cl [FREE_ENTRIES];
    logic             hv;
    logic [TOP_W-1:0] hs, hl;
    logic             shift_en;

    genvar g;
    generate
        for (g = 0; g < FREE_ENTRIES; g++) begin : g_cell
            if (g == 0) begin : g_head
                fha_cell #(.TOP_W(TOP_W)) u_cell (
                    .aclk, .aresetn, .shift_en,
                    .in_valid(hv), .in_start(hs), .in_len(hl),
                    .out_valid(cv[g]), .out_start(cs[g]), .out_len(cl[g])
                );
            end else begin : g_body
                fha_cell #(.TOP_W(TOP_W)) u_cell (
                    .aclk, .aresetn, .shift_en,
                    .in_valid(cv[g-1]), .in_start(cs[g-1]), .in_len(cl[g-1]),
                    .out_valid(cv[g]), .out_start(cs[g]), .out_len(cl[g])
                );
            end
        end
    endgenerate

    state_t state_reg, state_next;
    logic [STRAT_W-1:0] strat_reg;
    logic [TOP_W-1:0]   heap_top_reg, heap_top_next;
    logic [IW-1:0]      idx_reg;

    // request
    logic               act_reg;
    logic [REQ_W:0]     need_reg;
    logic [TOP_W-1:0]   addr_reg, flen_reg;
    logic [TOP_W:0]     end_reg;
    logic               inheap_reg;

    // scan results
    logic               best_ok_reg, pred_ok_reg, succ_ok_reg, slot_ok_reg;
    logic [IW-1:0]      best_idx_reg, pred_idx_reg, succ_idx_reg, slot_idx_reg;
    logic [TOP_W-1:0]   best_start_reg, best_len_reg, succ_len_reg;

    // result register
    logic               m_valid_reg;
    logic [ADDR_W-1:0]  gaddr_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [TOPOUT_W-1:0] top_out_reg;

    // tail entry seen by the scan
    logic             tv;
    logic [TOP_W-1:0] ts, tl;
    assign tv = cv[FREE_ENTRIES-1];
    assign ts = cs[FREE_ENTRIES-1];
    assign tl = cl[FREE_ENTRIES-1];

    logic [TOP_W-1:0] need_w;
    assign need_w = TOP_W'(need_reg);

    logic fit, better;
    always_comb begin
        fit = tv && (tl >= need_w);
        case (strat_reg)
            STRAT_BEST:  better = (tl < best_len_reg) ||
                                  ((tl == best_len_reg) && (ts <= best_start_reg));
            STRAT_WORST: better = (tl > best_len_reg) ||
                                  ((tl == best_len_reg) && (ts <= best_start_reg));
            default:     better = (ts <= best_start_reg);
        endcase
    end

    // accept-time clip of the freed block to the heap top
    logic [TOP_W-1:0] in_addr, room, in_need, in_flen;
    assign in_addr = TOP_W'(s_free_address);
    assign in_need = TOP_W'(s_request_length) + TOP_W'(1);
    assign room    = heap_top_reg - in_addr;
    assign in_flen = (in_need > room) ? room : in_need;

    // final decisions
    logic grow_ok;
    assign grow_ok = ({1'b0, heap_top_reg} + (TOP_W+1)'(need_reg)) <= (TOP_W+1)'(HEAP_UNITS);

    // apply path: modify tail entry on its way into the head cell
    logic [TOP_W+1:0] merged;
    always_comb begin
        hv = tv;
        hs = ts;
        hl = tl;
        merged = (TOP_W+2)'(tl) + (TOP_W+2)'(flen_reg);
        if (state_reg == S_APPLY) begin
            if (!act_reg) begin
                if (best_ok_reg && idx_reg == best_idx_reg) begin
                    if (tl == need_w) begin
                        hv = 1'b0;
                    end else begin
                        hs = ts + need_w;
                        hl = tl - need_w;
                    end
                end
            end else if (inheap_reg) begin
                if (pred_ok_reg) begin
                    if (idx_reg == pred_idx_reg) begin
                        if (succ_ok_reg) begin
                            merged = merged + (TOP_W+2)'(succ_len_reg);
                        end
                        hl = (merged > CAP) ? TOP_W'(CAP) : TOP_W'(merged);
                    end else if (succ_ok_reg && idx_reg == succ_idx_reg) begin
                        hv = 1'b0;
                    end
                end else if (succ_ok_reg) begin
                    if (idx_reg == succ_idx_reg) begin
                        hs = addr_reg;
                        hl = (merged > CAP) ? TOP_W'(CAP) : TOP_W'(merged);
                    end
                end else if (slot_ok_reg && idx_reg == slot_idx_reg) begin
                    hv = 1'b1;
                    hs = addr_reg;
                    hl = flen_reg;
                end
            end
        end
    end

    assign shift_en = (state_reg == S_SCAN) || (state_reg == S_APPLY);
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        heap_top_next = heap_top_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_SCAN;
            S_SCAN:  if (idx_reg == '0) state_next = S_APPLY;
            S_APPLY: if (idx_reg == '0) state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                    if (!act_reg && !best_ok_reg && grow_ok) begin
                        heap_top_next = heap_top_reg + need_w;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            strat_reg    <= STRAT_FIRST;
            heap_top_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            heap_top_reg <= heap_top_next;
            if (cfg_wr_en) begin
                strat_reg <= cfg_wr_data;
            end
            if (state_reg == S_DONE && state_next == S_IDLE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                idx_reg     <= LAST_IDX;
                act_reg     <= s_action;
                need_reg    <= (REQ_W+1)'(s_request_length) + (REQ_W+1)'(1);
                addr_reg    <= in_addr;
                flen_reg    <= in_flen;
                end_reg     <= (TOP_W+1)'(in_addr) + (TOP_W+1)'(in_flen);
                inheap_reg  <= in_addr < heap_top_reg;
                best_ok_reg <= 1'b0;
                pred_ok_reg <= 1'b0;
                succ_ok_reg <= 1'b0;
                slot_ok_reg <= 1'b0;
            end
            S_SCAN: begin
                // scan runs from the highest index down; ties go to the lower start address
                idx_reg <= (idx_reg == '0) ? LAST_IDX : idx_reg - IW'(1);
                if (fit && (!best_ok_reg || better)) begin
                    best_ok_reg    <= 1'b1;
                    best_idx_reg   <= idx_reg;
                    best_start_reg <= ts;
                    best_len_reg   <= tl;
                end
                if (tv && ((TOP_W+1)'(ts) + (TOP_W+1)'(tl)) == (TOP_W+1)'(addr_reg)) begin
                    pred_ok_reg  <= 1'b1;
                    pred_idx_reg <= idx_reg;
                end
                if (tv && (TOP_W+1)'(ts) == end_reg) begin
                    succ_ok_reg  <= 1'b1;
                    succ_idx_reg <= idx_reg;
                    succ_len_reg <= tl;
                end
                if (!tv) begin
                    slot_ok_reg  <= 1'b1;
                    slot_idx_reg <= idx_reg;
                end
            end
            S_APPLY: begin
                idx_reg <= idx_reg - IW'(1);
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    top_out_reg <= TOPOUT_W'(heap_top_next);
                    if (!act_reg) begin
                        if (best_ok_reg) begin
                            gaddr_reg  <= ADDR_W'(best_start_reg);
                            status_reg <= ST_REUSED;
                        end else if (grow_ok) begin
                            gaddr_reg  <= ADDR_W'(heap_top_reg);
                            status_reg <= ST_GREW;
                        end else begin
                            gaddr_reg  <= '0;
                            status_reg <= ST_HEAP_FULL;
                        end
                    end else begin
                        gaddr_reg <= '0;
                        if (inheap_reg && !pred_ok_reg && !succ_ok_reg && !slot_ok_reg) begin
                            status_reg <= ST_TABLE_FULL;
                        end else begin
                            status_reg <= ST_FREED;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_address = gaddr_reg;
    assign m_status          = status_reg;
    assign m_heap_top_now    = top_out_reg;

endmodule

`default_nettype wire

FILE: sv/fha_checker.sv
// ----------------------------------------------------------------------------
// fha_checker: port-level checks for the allocator
// Watches the result channel and the ordering of transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module fha_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [15:0] m_granted_address,
    input wire [2:0]  m_status,
    input wire [16:0] m_heap_top_now
);
    import fha_pkg::*;

    // hold the result until the transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
                                && $stable(m_granted_address))
        else $error("result dropped or changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_TABLE_FULL)
        else $error("status code out of range");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_HEAP_FULL || m_status == ST_FREED
                    || m_status == ST_TABLE_FULL) |-> m_granted_address == '0)
        else $error("address given without allocation");

    // a result never leaves in the cycle right after an input transfer
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

    a_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_GREW |-> m_heap_top_now != '0)
        else $error("heap grew but top is zero");

endmodule

bind fit_strategy_heap_allocator fha_checker u_fha_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_granted_address, .m_status, .m_heap_top_now
);

`default_nettype wire
